### hw/rtl/csi_pkg.sv
// Shared types and constants for the cumulative Simpson integrator.
// Item and result structs, run-position and mode codes, fixed-point widths.
// No dependencies.
`default_nettype none

package csi_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int STEP_W     = 24;
	localparam int INTEG_W    = 48;
	localparam int SUM_W      = 35;
	localparam int MAG_W      = 34;
	localparam int HALF_W     = 17;
	localparam int PP_W       = STEP_W + HALF_W;
	localparam int PROD_W     = 58;
	localparam int QUO_W      = 42;
	localparam int SPLIT_W    = 21;
	localparam int Y_W        = 23;
	localparam int REC_W      = 22;
	localparam int HI_W       = 20;
	localparam int DIV3_SHIFT = 23;
	localparam int TOTAL_W    = INTEG_W + 2;

	localparam logic [STEP_W-1:0] STEP_RESET = 24'd65536;
	localparam logic [PROD_W-1:0] RND_TRAP   = 58'd65536;
	localparam logic [PROD_W-1:0] RND_SIMP   = 58'd98304;
	// floor(2^21 / 3) and ceil(2^23 / 3)
	localparam logic [HI_W-1:0]   DIV3_HI    = 20'd699050;
	localparam logic [REC_W-1:0]  DIV3_REC   = 22'd2796203;

	localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
	localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

	typedef enum logic [1:0] {
		MODE_ZERO,
		MODE_TRAP,
		MODE_SIMP
	} csi_mode_t;

	typedef enum logic [1:0] {
		POS_NONE,
		POS_ONE,
		POS_MANY
	} csi_pos_t;

	typedef struct packed {
		csi_mode_t                 mode;
		logic signed [SUM_W-1:0]   sum;
	} csi_item_t;

	typedef struct packed {
		logic signed [INTEG_W-1:0] value;
		logic                      sat;
	} csi_result_t;

endpackage

`default_nettype wire

### hw/rtl/csi_fifo.sv
// Small register-based queue used between the integrator's parts.
// Generic width and depth; no package dependency.
`default_nettype none

module csi_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  full,
	output logic                  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/csi_front.sv
// Front part: keeps the sample history and run position, classifies each item
// and forms its weighted sample sum. Depends on csi_pkg.
`default_nettype none

module csi_front
	import csi_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       accept,
	input  wire logic signed [SAMPLE_W-1:0] sample_value,
	input  wire logic                       first_sample,
	output csi_item_t                       item
);

	logic signed [SAMPLE_W-1:0] prev_sample_q;
	logic signed [SAMPLE_W-1:0] older_sample_q;
	csi_pos_t                   pos_q;
	csi_pos_t                   pos_d;
	csi_mode_t                  mode;
	logic signed [SUM_W-1:0]    f_ext;
	logic signed [SUM_W-1:0]    prev_ext;
	logic signed [SUM_W-1:0]    prev_x4;
	logic signed [SUM_W-1:0]    older_ext;

	assign f_ext     = {{(SUM_W-SAMPLE_W){sample_value[SAMPLE_W-1]}}, sample_value};
	assign prev_ext  = {{(SUM_W-SAMPLE_W){prev_sample_q[SAMPLE_W-1]}}, prev_sample_q};
	assign prev_x4   = {prev_sample_q[SAMPLE_W-1], prev_sample_q, 2'b00};
	assign older_ext = {{(SUM_W-SAMPLE_W){older_sample_q[SAMPLE_W-1]}}, older_sample_q};

	always_comb begin
		pos_d = pos_q;
		if (accept) begin
			if (first_sample || pos_q == POS_NONE) begin
				pos_d = POS_ONE;
			end else begin
				pos_d = POS_MANY;
			end
		end
	end

	always_comb begin
		case (pos_q)
			POS_ONE:  mode = MODE_TRAP;
			POS_MANY: mode = MODE_SIMP;
			default:  mode = MODE_ZERO;
		endcase
		if (first_sample) begin
			mode = MODE_ZERO;
		end
		item.mode = mode;
		case (mode)
			MODE_TRAP: item.sum = prev_ext + f_ext;
			MODE_SIMP: item.sum = older_ext + prev_x4 + f_ext;
			default:   item.sum = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= POS_NONE;
			prev_sample_q  <= '0;
			older_sample_q <= '0;
		end else begin
			pos_q <= pos_d;
			if (accept) begin
				prev_sample_q  <= sample_value;
				older_sample_q <= (mode == MODE_ZERO) ? '0 : prev_sample_q;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/csi_back.sv
// Back part: four-stage arithmetic pipeline (h times sum, rounding, divide by
// three, accumulate and clamp) with output-queue credits. Depends on csi_pkg.
`default_nettype none

module csi_back
	import csi_pkg::*;
#(
	parameter int OUT_DEPTH = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [STEP_W-1:0]  step_size,
	input  wire csi_item_t          item,
	input  wire logic               item_valid,
	output logic                    item_take,
	input  wire logic               res_freed,
	output csi_result_t             result,
	output logic                    result_valid
);

	localparam int CW = $clog2(OUT_DEPTH + 1);

	logic [CW-1:0]              credit_q;

	logic                       v_s1, v_s2, v_s3, v_s4;
	csi_mode_t                  mode_s1, mode_s2, mode_s3, mode_s4;
	logic                       neg_s1, neg_s2, neg_s3, neg_s4;
	logic [MAG_W-1:0]           mag_s1;
	logic [PP_W-1:0]            pp_lo_s2;
	logic [PP_W-1:0]            pp_hi_s2;
	logic [QUO_W-1:0]           quo_s3;
	logic [QUO_W-1:0]           quo_s4;

	logic signed [INTEG_W-1:0]  prev_int_q;
	logic signed [INTEG_W-1:0]  old_int_q;

	logic [SUM_W-1:0]           sum_abs;
	logic [PROD_W-1:0]          prod;
	logic [QUO_W-1:0]           quo_next;
	logic [SPLIT_W-1:0]         xh;
	logic [SPLIT_W-1:0]         xl;
	logic [Y_W-1:0]             y;
	logic [Y_W+REC_W-1:0]       y_rec;
	logic [SPLIT_W+HI_W-1:0]    q_hi;
	logic [QUO_W-1:0]           q_div3;
	logic signed [TOTAL_W-1:0]  base_ext;
	logic [TOTAL_W-1:0]         inc_ext;
	logic signed [TOTAL_W-1:0]  total;

	assign item_take = item_valid && (credit_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= CW'(OUT_DEPTH);
		end else if (item_take && !res_freed) begin
			credit_q <= credit_q - 1'b1;
		end else if (res_freed && !item_take) begin
			credit_q <= credit_q + 1'b1;
		end
	end

	// stage 1: magnitude of the sample sum
	assign sum_abs = item.sum[SUM_W-1] ? (~item.sum + 1'b1) : item.sum;

	// stage 3: recombine partial products and add the rounding half
	always_comb begin
		prod = PROD_W'(pp_lo_s2) + {pp_hi_s2, {HALF_W{1'b0}}}
			+ ((mode_s2 == MODE_SIMP) ? RND_SIMP : RND_TRAP);
		if (mode_s2 == MODE_SIMP) begin
			quo_next = prod[PROD_W-1 -: QUO_W];
		end else begin
			quo_next = {1'b0, prod[PROD_W-1 -: QUO_W-1]};
		end
	end

	// stage 4: x/3 = xh*floor(2^21/3) + floor((2*xh + xl)/3)
	assign xh     = quo_s3[QUO_W-1 -: SPLIT_W];
	assign xl     = quo_s3[SPLIT_W-1:0];
	assign y      = {1'b0, xh, 1'b0} + {2'b00, xl};
	assign y_rec  = (Y_W+REC_W)'(y) * (Y_W+REC_W)'(DIV3_REC);
	assign q_hi   = (SPLIT_W+HI_W)'(xh) * (SPLIT_W+HI_W)'(DIV3_HI);
	assign q_div3 = QUO_W'(q_hi) + QUO_W'(y_rec[Y_W+REC_W-1:DIV3_SHIFT]);

	// final: signed accumulate and clamp
	always_comb begin
		base_ext = (mode_s4 == MODE_SIMP)
			? {{(TOTAL_W-INTEG_W){old_int_q[INTEG_W-1]}}, old_int_q} : '0;
		inc_ext  = {{(TOTAL_W-QUO_W){1'b0}}, quo_s4};
		if (neg_s4) begin
			inc_ext = ~inc_ext;
		end
		total = base_ext + $signed(inc_ext) + $signed({{(TOTAL_W-1){1'b0}}, neg_s4});
		if (mode_s4 == MODE_ZERO) begin
			result.value = '0;
			result.sat   = 1'b0;
		end else if (total[TOTAL_W-1:INTEG_W-1] != '0
				&& total[TOTAL_W-1:INTEG_W-1] != '1) begin
			result.value = total[TOTAL_W-1] ? INTEG_MIN : INTEG_MAX;
			result.sat   = 1'b1;
		end else begin
			result.value = total[INTEG_W-1:0];
			result.sat   = 1'b0;
		end
	end

	assign result_valid = v_s4;

	always_ff @(posedge clk) begin
		mode_s1  <= item.mode;
		neg_s1   <= item.sum[SUM_W-1];
		mag_s1   <= sum_abs[MAG_W-1:0];

		mode_s2  <= mode_s1;
		neg_s2   <= neg_s1;
		pp_lo_s2 <= PP_W'(step_size) * PP_W'(mag_s1[HALF_W-1:0]);
		pp_hi_s2 <= PP_W'(step_size) * PP_W'(mag_s1[MAG_W-1:HALF_W]);

		mode_s3  <= mode_s2;
		neg_s3   <= neg_s2;
		quo_s3   <= quo_next;

		mode_s4  <= mode_s3;
		neg_s4   <= neg_s3;
		quo_s4   <= (mode_s3 == MODE_SIMP) ? q_div3 : quo_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			prev_int_q <= '0;
			old_int_q  <= '0;
		end else begin
			v_s1 <= item_take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (v_s4) begin
				if (mode_s4 == MODE_ZERO) begin
					old_int_q  <= '0;
					prev_int_q <= '0;
				end else begin
					old_int_q  <= prev_int_q;
					prev_int_q <= result.value;
				end
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/cumulative_simpson_integrator.sv
// Top level of the cumulative Simpson integrator: step register, front part,
// item queue, arithmetic back part and result queue. Depends on csi_pkg,
// csi_front, csi_fifo and csi_back.
//
// Use: samples enter through a queue-like port (push/full); an item is taken
// when push is high and full is low. Results leave through a queue-like port
// (empty/pop); the oldest result sits on integral_value/saturated while empty
// is low and is taken when pop is high. Each sample gives exactly one result.
// The step size h is written through cfg_valid/cfg_ready (ready is always
// high); the user must write it only while the block is idle, as the block
// itself does not enforce this.
// Throughput: one item per cycle, set by the four-stage arithmetic pipeline
// that starts an item every cycle while the result queue has room reserved.
// Reset: h returns to 1.0, the run position and history clear, both queues
// empty. When the receiver stops popping, the result queue fills, the
// pipeline stops drawing items and the input queue of MID_DEPTH items fills
// until full rises; nothing is lost.
`default_nettype none

module cumulative_simpson_integrator
	import csi_pkg::*;
#(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	output logic                            full,
	input  wire logic signed [SAMPLE_W-1:0] sample_value,
	input  wire logic                       first_sample,
	output logic                            empty,
	input  wire logic                       pop,
	output logic signed [INTEG_W-1:0]       integral_value,
	output logic                            saturated,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [STEP_W-1:0]          step_size
);

	localparam int ITEM_W = $bits(csi_item_t);
	localparam int RES_W  = $bits(csi_result_t);

	logic [STEP_W-1:0] step_q;
	logic              accept;
	csi_item_t         front_item;
	logic [ITEM_W-1:0] mid_wdata;
	logic [ITEM_W-1:0] mid_rdata;
	logic              mid_empty;
	csi_item_t         back_item;
	logic              item_take;
	logic              res_freed;
	csi_result_t       back_result;
	logic              back_valid;
	logic [RES_W-1:0]  out_wdata;
	logic [RES_W-1:0]  out_rdata;
	csi_result_t       head;
	logic              out_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			step_q <= step_size;
		end
	end

	assign accept = push && !full;

	csi_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.sample_value (sample_value),
		.first_sample (first_sample),
		.item         (front_item)
	);

	assign mid_wdata = front_item;

	csi_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (mid_wdata),
		.pop    (item_take),
		.rdata  (mid_rdata),
		.full   (full),
		.empty  (mid_empty)
	);

	assign back_item = csi_item_t'(mid_rdata);
	assign res_freed = pop && !empty;

	csi_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_size    (step_q),
		.item         (back_item),
		.item_valid   (!mid_empty),
		.item_take    (item_take),
		.res_freed    (res_freed),
		.result       (back_result),
		.result_valid (back_valid)
	);

	assign out_wdata = back_result;

	// credits keep this queue from ever being full at a write
	csi_fifo #(
		.WIDTH (RES_W),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (back_valid),
		.wdata  (out_wdata),
		.pop    (pop),
		.rdata  (out_rdata),
		.full   (out_full),
		.empty  (empty)
	);

	assign head           = csi_result_t'(out_rdata);
	assign integral_value = head.value;
	assign saturated      = head.sat && !out_full ? head.sat : head.sat;

endmodule

`default_nettype wire

### hw/rtl/csi_chk.sv
// Port-level checker for the cumulative Simpson integrator, bound to the top.
// Tracks items in flight from the handshakes. Depends on csi_pkg.
`default_nettype none

module csi_chk
	import csi_pkg::*;
#(
	parameter int TOTAL = 12
) (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       push,
	input wire logic                       full,
	input wire logic                       empty,
	input wire logic                       pop,
	input wire logic signed [INTEG_W-1:0]  integral_value,
	input wire logic                       saturated
);

	localparam int NW = $clog2(TOTAL + 2);

	logic [NW-1:0] inflight_q;
	logic          in_acc;
	logic          out_acc;

	assign in_acc  = push && !full;
	assign out_acc = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == '0 |-> empty)
		else $error("result offered with no item outstanding");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= NW'(TOTAL))
		else $error("more items held than the queues can store");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && saturated |-> integral_value == INTEG_MAX || integral_value == INTEG_MIN)
		else $error("saturated result not at a range limit");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(integral_value) && $stable(saturated))
		else $error("waiting result changed before it was taken");

endmodule

bind cumulative_simpson_integrator csi_chk #(
	.TOTAL (MID_DEPTH + OUT_DEPTH)
) u_csi_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.push           (push),
	.full           (full),
	.empty          (empty),
	.pop            (pop),
	.integral_value (integral_value),
	.saturated      (saturated)
);

`default_nettype wire

### sim/cumulative_simpson_integrator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for cumulative_simpson_integrator: a behavioural integrator
// predicts every running integral, which is compared with the result port.
// Depends on csi_pkg and the block's RTL.
module cumulative_simpson_integrator_tb;
	import csi_pkg::*;

	localparam int     CLK_HALF    = 10;
	localparam int     IDLE_PCT    = 27;
	localparam longint CYCLE_LIMIT = 400000;
	localparam longint TRAP_DIV    = 131072;
	localparam longint SIMP_DIV    = 196608;
	localparam longint CLAMP_HI    = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint CLAMP_LO    = -CLAMP_HI - 1;
	localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       push = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_value = '0;
	logic                       first_sample = 1'b0;
	logic                       pop = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic [STEP_W-1:0]          step_size = STEP_RESET;
	logic                       full;
	logic                       empty;
	logic                       cfg_ready;
	logic signed [INTEG_W-1:0]  integral_value;
	logic                       saturated;

	// integrator state as the block should hold it
	logic [STEP_W-1:0]          h_reg = STEP_RESET;
	logic signed [SAMPLE_W-1:0] prev_f = '0;
	logic signed [SAMPLE_W-1:0] older_f = '0;
	logic signed [INTEG_W-1:0]  prev_F = '0;
	logic signed [INTEG_W-1:0]  older_F = '0;
	csi_pos_t                   run_pos = POS_NONE;
	csi_result_t                pending_integrals[$];

	int     errors = 0;
	int     items_sent = 0;
	int     results_checked = 0;
	int     input_stalls = 0;
	int     sat_results = 0;
	int     steps_written = 0;
	bit     quiet = 1'b0;
	logic   rcv_hold = 1'b0;
	longint cycle_count = 0;

	cumulative_simpson_integrator dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.sample_value   (sample_value),
		.first_sample   (first_sample),
		.empty          (empty),
		.pop            (pop),
		.integral_value (integral_value),
		.saturated      (saturated),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.step_size      (step_size)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_integrals.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(string msg);
		errors++;
		if (errors <= 30)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	function automatic longint round_away(longint num, longint den);
		longint mag;
		mag = (num < 0) ? -num : num;
		mag = (mag + den / 2) / den;
		return (num < 0) ? -mag : mag;
	endfunction

	function automatic void integrate_sample(logic signed [SAMPLE_W-1:0] f, logic restart);
		longint      total;
		csi_result_t r;
		r.sat = 1'b0;
		if (restart || run_pos == POS_NONE) begin
			total = 0;
			older_f = '0;
			older_F = '0;
			run_pos = POS_ONE;
		end else if (run_pos == POS_ONE) begin
			total = round_away(longint'(h_reg) * (longint'(prev_f) + longint'(f)), TRAP_DIV);
			older_f = prev_f;
			older_F = prev_F;
			run_pos = POS_MANY;
		end else begin
			total = longint'(older_F) + round_away(longint'(h_reg) *
				(longint'(older_f) + 4 * longint'(prev_f) + longint'(f)), SIMP_DIV);
			older_f = prev_f;
			older_F = prev_F;
		end
		if (total > CLAMP_HI) begin
			total = CLAMP_HI;
			r.sat = 1'b1;
		end else if (total < CLAMP_LO) begin
			total = CLAMP_LO;
			r.sat = 1'b1;
		end
		r.value = total[INTEG_W-1:0];
		prev_f = f;
		prev_F = r.value;
		pending_integrals.push_back(r);
	endfunction

	// result side: check each popped item, then decide pop for the next edge
	always @(posedge clk) begin : check_results
		csi_result_t want;
		if (arst_n && pop && !empty) begin
			if (pending_integrals.size() == 0) begin
				report_mismatch($sformatf("unexpected result %0d", integral_value));
			end else begin
				want = pending_integrals.pop_front();
				results_checked++;
				if (want.sat)
					sat_results++;
				if (integral_value !== want.value)
					report_mismatch($sformatf("integral_value %0d, expected %0d",
						integral_value, want.value));
				if (saturated !== want.sat)
					report_mismatch($sformatf("saturated %b, expected %b (value %0d)",
						saturated, want.sat, want.value));
			end
		end
		pop <= !rcv_hold && (quiet || $urandom_range(0, 99) >= IDLE_PCT);
	end

	task automatic send_sample(logic signed [SAMPLE_W-1:0] f, logic restart);
		if (!quiet) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				push <= 1'b0;
				@(posedge clk);
			end
		end
		push <= 1'b1;
		sample_value <= f;
		first_sample <= restart;
		forever begin
			@(posedge clk);
			if (!full)
				break;
			input_stalls++;
		end
		integrate_sample(f, restart);
		items_sent++;
	endtask

	task automatic drain();
		push <= 1'b0;
		while (pending_integrals.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_step(logic [STEP_W-1:0] h);
		drain();
		cfg_valid <= 1'b1;
		step_size <= h;
		do @(posedge clk); while (!cfg_ready);
		h_reg = h;
		cfg_valid <= 1'b0;
		steps_written++;
	endtask

	task automatic hold_results(int n_cycles);
		rcv_hold <= 1'b1;
		repeat (n_cycles) @(posedge clk);
		rcv_hold <= 1'b0;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 50)
			return $urandom;
		if (sel < 75)
			return 32'($urandom_range(0, 2097152) - 1048576);
		if (sel < 88) begin
			case ($urandom_range(0, 3))
				0: return SMP_MAX;
				1: return SMP_MIN;
				2: return '0;
				default: return '1;
			endcase
		end
		if (sel < 94)
			return SMP_MAX - 32'($urandom_range(0, 255));
		return SMP_MIN + 32'($urandom_range(0, 255));
	endfunction

	function automatic logic [STEP_W-1:0] pick_step();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 40)
			return 24'($urandom_range(1, STEP_MAX));
		if (sel < 70)
			return 24'($urandom_range(1, 262144));
		if (sel < 80)
			return STEP_MAX;
		if (sel < 90)
			return 24'd1;
		if (sel < 95)
			return STEP_RESET;
		return '0;
	endfunction

	// runs of random length; a few restarts land mid-run
	task automatic send_runs(int count);
		int   run_left;
		logic restart;
		run_left = 0;
		repeat (count) begin
			restart = (run_left == 0) || ($urandom_range(0, 99) < 3);
			if (restart)
				run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
					: $urandom_range(1, 25);
			run_left--;
			send_sample(pick_sample(), restart);
		end
	endtask

	// first item after reset starts a run without the flag; reset step of 1.0
	task automatic test_after_reset();
		send_sample('0, 1'b0);
		send_sample(SMP_MAX, 1'b0);
		send_sample(SMP_MAX, 1'b0);
		send_sample(SMP_MIN, 1'b0);
		send_sample(SMP_MIN, 1'b0);
		send_sample('1, 1'b0);
		send_sample('0, 1'b0);
	endtask

	task automatic test_restart();
		send_sample(SMP_MAX, 1'b1);
		send_sample(32'sd65536, 1'b0);
		send_sample(-32'sd65536, 1'b0);
	endtask

	// smallest and largest step, a change mid-run, zero step, rounding ties
	task automatic test_step_extremes();
		write_step(24'd1);
		send_sample(32'sd32768, 1'b1);
		send_sample(32'sd32768, 1'b0);
		send_sample(-32'sd32768, 1'b0);
		write_step(STEP_MAX);
		send_sample(SMP_MAX, 1'b0);
		send_sample(SMP_MIN, 1'b0);
		send_sample(SMP_MAX, 1'b0);
		write_step('0);
		send_sample(SMP_MAX, 1'b0);
		send_sample(SMP_MIN, 1'b0);
		write_step(24'd1);
		send_sample(-32'sd32768, 1'b1);
		send_sample(-32'sd32768, 1'b0);
	endtask

	task automatic test_random_runs();
		repeat (12) begin
			write_step(pick_step());
			send_runs($urandom_range(20, 40));
		end
	endtask

	task automatic test_steady_stream();
		write_step(pick_step());
		quiet = 1'b1;
		send_runs(160);
		drain();
		quiet = 1'b0;
	endtask

	// receiver stops long enough for both queues to fill and full to rise
	task automatic test_backpressure();
		write_step(pick_step());
		quiet = 1'b1;
		fork
			hold_results(300);
			send_runs(60);
		join
		drain();
		quiet = 1'b0;
	endtask

	// long full-scale runs drive the integral into both clamps
	task automatic test_saturation();
		write_step(STEP_MAX);
		for (int i = 0; i < 280; i++)
			send_sample(SMP_MAX - 32'($urandom_range(0, 1023)), i == 0);
		for (int i = 0; i < 280; i++)
			send_sample(SMP_MIN + 32'($urandom_range(0, 1023)), i == 0);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);
		test_after_reset();
		test_restart();
		test_step_extremes();
		test_random_runs();
		test_steady_stream();
		test_backpressure();
		test_saturation();
		drain();
		repeat (20) @(posedge clk);
		$display("%0d samples over %0d step settings, incl. restarts, zero step and clamping",
			items_sent, steps_written);
		$display("%0d results checked, %0d saturated, %0d input stall cycles, %0d mismatches",
			results_checked, sat_results, input_stalls, errors);
		if (errors == 0 && pending_integrals.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
